// ===== hw/rtl/ocv_pkg.sv =====
// ----------------------------------------------------------------------------
// ocv_pkg
// Shared types, codes and helper functions for the chunk verifier.
// ----------------------------------------------------------------------------
package ocv_pkg;

    localparam int unsigned DEFAULT_BUFFER_BYTES = 4096;

    localparam int unsigned CNT_W     = 13;
    localparam int unsigned PACK_W    = 16;
    localparam int unsigned CRC_W     = 16;
    localparam int unsigned WRITTEN_W = 24;
    localparam int unsigned S_DATA_W  = 40;
    localparam int unsigned M_DATA_W  = 56;
    localparam int unsigned CFG_IDX_W = 1;

    localparam logic [CRC_W-1:0]     CRC_INIT    = 16'hFFFF;
    localparam logic [CRC_W-1:0]     CRC_POLY    = 16'hA001;
    localparam logic [3:0]           OFFSET_INIT = 4'b1000;  // minus eight
    localparam logic [PACK_W-1:0]    PACK_FIRST  = 16'd1;
    localparam logic [WRITTEN_W-1:0] WRITTEN_MAX = 24'hFFFFFF;

    // request kinds
    localparam logic REQ_START = 1'b0;
    localparam logic REQ_CHAR  = 1'b1;

    // result kinds
    localparam logic KIND_DATA   = 1'b0;
    localparam logic KIND_REPORT = 1'b1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_DECODE_LIMIT = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_CHUNK    = 1'd1;

    localparam logic [CNT_W-1:0] CFG_RESET_VALUE = 13'd1024;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_SEQUENCE  = 2'd1,
        ST_DECODE    = 2'd2,
        ST_CRC       = 2'd3
    } status_t;

    typedef struct packed {
        logic              req_type;
        logic [PACK_W-1:0] pack_number;
        logic [CRC_W-1:0]  expected_crc;
        logic [7:0]        char_code;
        logic              last_char;
    } in_item_t;

    typedef struct packed {
        logic                 kind;
        logic [7:0]           data_byte;
        status_t              status;
        logic [PACK_W-1:0]    reported_pack;
        logic [WRITTEN_W-1:0] total_written;
        logic                 last;
    } result_t;

    typedef struct packed {
        logic [1:0] cnt;
        result_t    r0;
        result_t    r1;
    } result_pair_t;

    // base64 alphabet lookup: {valid, sextet}
    function automatic logic [6:0] sextet_of(input logic [7:0] c);
        logic [7:0] d;
        logic [6:0] r;
        d = 8'd0;
        r = 7'd0;
        if (c >= 8'h41 && c <= 8'h5A) begin          // A-Z
            d = c - 8'h41;
            r = {1'b1, d[5:0]};
        end else if (c >= 8'h61 && c <= 8'h7A) begin // a-z
            d = c - 8'h61 + 8'd26;
            r = {1'b1, d[5:0]};
        end else if (c >= 8'h30 && c <= 8'h39) begin // 0-9
            d = c - 8'h30 + 8'd52;
            r = {1'b1, d[5:0]};
        end else if (c == 8'h2B) begin               // plus
            r = {1'b1, 6'd62};
        end else if (c == 8'h2F) begin               // slash
            r = {1'b1, 6'd63};
        end
        return r;
    endfunction

    // crc-16/modbus, one byte
    function automatic logic [CRC_W-1:0] crc_byte(input logic [CRC_W-1:0] crc_in,
                                                  input logic [7:0] b);
        logic [CRC_W-1:0] c;
        c = crc_in ^ {8'd0, b};
        for (int i = 0; i < 8; i++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

// ===== hw/rtl/ocv_core.sv =====
// ----------------------------------------------------------------------------
// ocv_core
// Session and chunk state, base64 decode, crc update and chunk verdict.
// ----------------------------------------------------------------------------
module ocv_core #(
    parameter int unsigned BUFFER_BYTES = ocv_pkg::DEFAULT_BUFFER_BYTES
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       fire,
    input  ocv_pkg::in_item_t          item,
    input  logic [ocv_pkg::CNT_W-1:0]  decode_limit,
    input  logic [ocv_pkg::CNT_W-1:0]  max_chunk_bytes,
    output ocv_pkg::result_pair_t      pair
);
    import ocv_pkg::*;

    localparam int unsigned BUF_CAP = (BUFFER_BYTES > 8191) ? 8191 : BUFFER_BYTES;
    localparam logic [CNT_W-1:0] BUF_CAP_W = CNT_W'(BUF_CAP);

    logic [PACK_W-1:0]    expected_pack_reg, expected_pack_next;
    logic [WRITTEN_W-1:0] bytes_written_reg, bytes_written_next;
    logic [11:0]          bit_accum_reg, bit_accum_next;
    logic [3:0]           bit_offset_reg, bit_offset_next;
    logic [CNT_W-1:0]     byte_count_reg, byte_count_next;
    logic [CRC_W-1:0]     crc_acc_reg, crc_acc_next;
    logic                 overflow_seen_reg, overflow_seen_next;

    logic [6:0]           sx;
    logic [CNT_W-1:0]     limit;
    logic [11:0]          acc_shift;
    logic [3:0]           off_add;
    logic [7:0]           byte_val;
    logic                 have_byte;
    logic                 pack_match;
    logic                 report;
    logic [WRITTEN_W:0]   sum;
    logic [WRITTEN_W-1:0] written_sat;
    status_t              st;
    result_t              data_res;
    result_t              rep_res;

    always_comb begin
        sx         = sextet_of(item.char_code);
        limit      = (decode_limit < BUF_CAP_W) ? decode_limit : BUF_CAP_W;
        acc_shift  = {bit_accum_reg[5:0], sx[5:0]};
        off_add    = bit_offset_reg + 4'd6;
        byte_val   = 8'(acc_shift >> off_add[2:0]);
        have_byte  = 1'b0;
        pack_match = (item.pack_number != '0) && (item.pack_number == expected_pack_reg);

        expected_pack_next = expected_pack_reg;
        bytes_written_next = bytes_written_reg;
        bit_accum_next     = bit_accum_reg;
        bit_offset_next    = bit_offset_reg;
        byte_count_next    = byte_count_reg;
        crc_acc_next       = crc_acc_reg;
        overflow_seen_next = overflow_seen_reg;

        if (pack_match && !overflow_seen_reg && sx[6]) begin
            bit_accum_next  = acc_shift;
            bit_offset_next = off_add;
            // sign bit clear: a whole byte is in the accumulator
            if (!off_add[3]) begin
                if (byte_count_reg >= limit) begin
                    overflow_seen_next = 1'b1;
                end else begin
                    have_byte       = 1'b1;
                    byte_count_next = byte_count_reg + 1'b1;
                    crc_acc_next    = crc_byte(crc_acc_reg, byte_val);
                end
                bit_offset_next = off_add - 4'd8;
            end
        end

        report = item.last_char && (item.pack_number != '0);

        if (item.pack_number != expected_pack_reg) begin
            st = ST_SEQUENCE;
        end else if (byte_count_next == '0 || overflow_seen_next ||
                     byte_count_next > max_chunk_bytes) begin
            st = ST_DECODE;
        end else if (item.expected_crc != '0 && item.expected_crc != crc_acc_next) begin
            st = ST_CRC;
        end else begin
            st = ST_OK;
        end

        sum         = {1'b0, bytes_written_reg} + {{(WRITTEN_W+1-CNT_W){1'b0}}, byte_count_next};
        written_sat = sum[WRITTEN_W] ? WRITTEN_MAX : sum[WRITTEN_W-1:0];

        if (report && st == ST_OK) begin
            bytes_written_next = written_sat;
            expected_pack_next = expected_pack_reg + 1'b1;
        end

        if (item.last_char) begin
            bit_accum_next     = '0;
            bit_offset_next    = OFFSET_INIT;
            byte_count_next    = '0;
            crc_acc_next       = CRC_INIT;
            overflow_seen_next = 1'b0;
        end

        if (item.req_type == REQ_START) begin
            expected_pack_next = PACK_FIRST;
            bytes_written_next = '0;
            bit_accum_next     = '0;
            bit_offset_next    = OFFSET_INIT;
            byte_count_next    = '0;
            crc_acc_next       = CRC_INIT;
            overflow_seen_next = 1'b0;
        end

        data_res.kind          = KIND_DATA;
        data_res.data_byte     = byte_val;
        data_res.status        = ST_OK;
        data_res.reported_pack = '0;
        data_res.total_written = bytes_written_reg;
        data_res.last          = !report;

        rep_res.kind          = KIND_REPORT;
        rep_res.data_byte     = '0;
        rep_res.status        = st;
        rep_res.reported_pack = (st == ST_SEQUENCE) ? expected_pack_reg : item.pack_number;
        rep_res.total_written = (st == ST_OK) ? written_sat : bytes_written_reg;
        rep_res.last          = 1'b1;

        pair.r1 = rep_res;
        if (item.req_type == REQ_START) begin
            pair.cnt = 2'd0;
            pair.r0  = data_res;
        end else if (have_byte) begin
            pair.cnt = report ? 2'd2 : 2'd1;
            pair.r0  = data_res;
        end else begin
            pair.cnt = report ? 2'd1 : 2'd0;
            pair.r0  = rep_res;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            expected_pack_reg <= PACK_FIRST;
            bytes_written_reg <= '0;
            bit_accum_reg     <= '0;
            bit_offset_reg    <= OFFSET_INIT;
            byte_count_reg    <= '0;
            crc_acc_reg       <= CRC_INIT;
            overflow_seen_reg <= 1'b0;
        end else if (fire) begin
            expected_pack_reg <= expected_pack_next;
            bytes_written_reg <= bytes_written_next;
            bit_accum_reg     <= bit_accum_next;
            bit_offset_reg    <= bit_offset_next;
            byte_count_reg    <= byte_count_next;
            crc_acc_reg       <= crc_acc_next;
            overflow_seen_reg <= overflow_seen_next;
        end
    end

endmodule

// ===== hw/rtl/ocv_out_buf.sv =====
// ----------------------------------------------------------------------------
// ocv_out_buf
// Two-slot result register; drains one result per cycle to the stream while out_ready is high.
// ----------------------------------------------------------------------------
module ocv_out_buf (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  load,
    input  ocv_pkg::result_pair_t pair,
    output logic                  load_ok,
    output logic                  out_valid,
    input  logic                  out_ready,
    output ocv_pkg::result_t      out_res
);
    import ocv_pkg::*;

    logic    a_valid_reg, a_valid_next;
    logic    b_valid_reg, b_valid_next;
    result_t a_reg, a_next;
    result_t b_reg, b_next;
    logic    pop;

    assign pop       = a_valid_reg && out_ready;
    assign load_ok   = !a_valid_reg || (pop && !b_valid_reg);
    assign out_valid = a_valid_reg;
    assign out_res   = a_reg;

    always_comb begin
        a_valid_next = a_valid_reg;
        b_valid_next = b_valid_reg;
        a_next       = a_reg;
        b_next       = b_reg;
        if (pop) begin
            a_valid_next = b_valid_reg;
            a_next       = b_reg;
            b_valid_next = 1'b0;
        end
        if (load && pair.cnt != 2'd0) begin
            a_valid_next = 1'b1;
            a_next       = pair.r0;
            b_valid_next = (pair.cnt == 2'd2);
            b_next       = pair.r1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end else begin
            a_valid_reg <= a_valid_next;
            b_valid_reg <= b_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        a_reg <= a_next;
        b_reg <= b_next;
    end

endmodule

// ===== hw/rtl/ota_chunk_base64_crc_verifier.sv =====
// ----------------------------------------------------------------------------
// ota_chunk_base64_crc_verifier
// Base64 chunk decoder with crc-16/modbus check and sequence tracking.
// ----------------------------------------------------------------------------
// One base64 character enters per item and the block accepts a new item every
// cycle unless the held item's results do not yet fit in the result register.
// Each character passes an input register, then the decode, crc and verdict
// logic, and lands in a two-slot result register; results leave on m_ at one
// per cycle while m_tready is high. An item that completes a byte on the last
// character of a chunk with a nonzero number gives two results (the byte, then
// the chunk report), both through the single output port; an item that gives no
// result does not wait for the output. Configuration writes are taken at any
// time with cfg_ready held high, and must only be made while idle.
module ota_chunk_base64_crc_verifier #(
    parameter int unsigned BUFFER_BYTES = ocv_pkg::DEFAULT_BUFFER_BYTES
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // pack_number, expected_crc, char_code
    input  logic [ocv_pkg::S_DATA_W-1:0]  s_tdata,
    // req_type
    input  logic [0:0]                    s_tuser,
    input  logic                          s_tlast,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // data_byte, status, reported_pack, total_written, zero pad
    output logic [ocv_pkg::M_DATA_W-1:0]  m_tdata,
    // kind
    output logic [0:0]                    m_tuser,
    output logic                          m_tlast,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [ocv_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [ocv_pkg::CNT_W-1:0]     cfg_data
);
    import ocv_pkg::*;

    logic             in_valid_reg;
    in_item_t         in_item_reg;
    logic [CNT_W-1:0] decode_limit_reg;
    logic [CNT_W-1:0] max_chunk_reg;
    result_pair_t     pair;
    result_t          out_res;
    logic             load_ok;
    logic             fire;

    assign fire     = in_valid_reg && (load_ok || pair.cnt == 2'd0);
    assign s_tready = !in_valid_reg || fire;
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_item_reg.req_type     <= s_tuser[0];
            in_item_reg.pack_number  <= s_tdata[15:0];
            in_item_reg.expected_crc <= s_tdata[31:16];
            in_item_reg.char_code    <= s_tdata[39:32];
            in_item_reg.last_char    <= s_tlast;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            decode_limit_reg <= CFG_RESET_VALUE;
            max_chunk_reg    <= CFG_RESET_VALUE;
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_DECODE_LIMIT: decode_limit_reg <= cfg_data;
                CFG_MAX_CHUNK:    max_chunk_reg    <= cfg_data;
                default: ;
            endcase
        end
    end

    ocv_core #(
        .BUFFER_BYTES(BUFFER_BYTES)
    ) u_core (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .fire            (fire),
        .item            (in_item_reg),
        .decode_limit    (decode_limit_reg),
        .max_chunk_bytes (max_chunk_reg),
        .pair            (pair)
    );

    ocv_out_buf u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .load      (fire),
        .pair      (pair),
        .load_ok   (load_ok),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_res   (out_res)
    );

    assign m_tdata = {6'd0, out_res.total_written, out_res.reported_pack,
                      out_res.status, out_res.data_byte};
    assign m_tuser = out_res.kind;
    assign m_tlast = out_res.last;

endmodule

// ===== hw/rtl/ocv_checker.sv =====
// ----------------------------------------------------------------------------
// ocv_checker
// Port-level checks on the result stream of the chunk verifier.
// ----------------------------------------------------------------------------
module ocv_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [ocv_pkg::M_DATA_W-1:0]  m_tdata,
    input logic [0:0]                    m_tuser,
    input logic                          m_tlast
);
    import ocv_pkg::*;

    // a stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // a chunk report always closes the results of its item
    a_report_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] == KIND_REPORT |-> m_tlast)
        else $error("report without last");

    // a data item carries no status or chunk number
    a_data_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] == KIND_DATA |-> m_tdata[25:8] == '0)
        else $error("data item with report fields");

    // a data item that is not last is followed by its report once taken
    a_pair: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready && m_tuser[0] == KIND_DATA && !m_tlast
        |=> m_tvalid && m_tuser[0] == KIND_REPORT)
        else $error("byte not followed by its report");

endmodule

bind ota_chunk_base64_crc_verifier ocv_checker u_ocv_checker (.*);

// ===== tb/tb_ota_chunk_base64_crc_verifier.sv =====
// ----------------------------------------------------------------------------
// tb_ota_chunk_base64_crc_verifier
// Self-checking bench for the base64 chunk decoder with crc and sequence check.
// A built-in predictor tracks session, decoder and crc state for each item
// that the block takes and queues the data bytes and chunk reports it should
// produce. A directed pass covers the corner cases. Random streams of
// well-formed chunks mixed with noise then run under several limit settings
// and idle patterns.
// ----------------------------------------------------------------------------
module tb_ota_chunk_base64_crc_verifier;
    import ocv_pkg::*;

    localparam string B64_CHARS =
        "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";
    localparam int BUF_BYTES   = DEFAULT_BUFFER_BYTES;
    localparam int DRAIN_LIMIT = 20000;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_DATA_W-1:0]  s_tdata = '0;
    logic [0:0]           s_tuser = REQ_START;
    logic                 s_tlast = 1'b0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_DATA_W-1:0]  m_tdata;
    logic [0:0]           m_tuser;
    logic                 m_tlast;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = CFG_DECODE_LIMIT;
    logic [CNT_W-1:0]     cfg_data = '0;

    ota_chunk_base64_crc_verifier uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    always #5 aclk = ~aclk;

    // predicted block state
    logic [CNT_W-1:0]     decode_limit_q = CFG_RESET_VALUE;
    logic [CNT_W-1:0]     max_chunk_q    = CFG_RESET_VALUE;
    logic [PACK_W-1:0]    next_pack      = PACK_FIRST;
    logic [WRITTEN_W-1:0] written_total  = '0;
    logic [11:0]          bit_window     = '0;
    int                   bit_pos        = -8;
    int                   chunk_bytes    = 0;
    logic [CRC_W-1:0]     chunk_crc      = CRC_INIT;
    logic                 chunk_overflow = 1'b0;

    result_t    due_results[$];
    logic [7:0] payload[$];
    logic [7:0] chunk_text[$];

    int tx_idle_pct  = 0;
    int rx_stall_pct = 0;
    int items_sent   = 0;
    int results_seen = 0;
    int mismatches   = 0;
    int reports_by_status[4] = '{0, 0, 0, 0};

    function automatic int b64_value(input logic [7:0] ch);
        if (ch >= "A" && ch <= "Z") return int'(ch - "A");
        if (ch >= "a" && ch <= "z") return int'(ch - "a") + 26;
        if (ch >= "0" && ch <= "9") return int'(ch - "0") + 52;
        if (ch == "+") return 62;
        if (ch == "/") return 63;
        return -1;
    endfunction

    function automatic logic [CRC_W-1:0] crc16_step(input logic [CRC_W-1:0] acc,
                                                    input logic [7:0] b);
        logic [CRC_W-1:0] c;
        c = acc ^ {8'h00, b};
        repeat (8) c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        return c;
    endfunction

    task automatic clear_chunk_state();
        bit_window     = '0;
        bit_pos        = -8;
        chunk_bytes    = 0;
        chunk_crc      = CRC_INIT;
        chunk_overflow = 1'b0;
    endtask

    task automatic push_due(input logic kind, input logic [7:0] data, input status_t st,
                            input logic [PACK_W-1:0] pack, input logic fin);
        result_t r;
        r.kind          = kind;
        r.data_byte     = data;
        r.status        = st;
        r.reported_pack = pack;
        r.total_written = written_total;
        r.last          = fin;
        due_results.push_back(r);
    endtask

    // decode one accepted item and queue what the block must emit for it
    task automatic advance_decoder(input logic req, input logic [PACK_W-1:0] pack,
                                   input logic [CRC_W-1:0] ecrc, input logic [7:0] ch,
                                   input logic fin);
        int         sx;
        int         cap;
        logic       got;
        logic [7:0] val;
        logic [11:0] shifted;
        logic [24:0] sum;
        got = 1'b0;
        val = '0;
        if (req == REQ_START) begin
            next_pack     = PACK_FIRST;
            written_total = '0;
            clear_chunk_state();
            return;
        end
        if (pack != 0 && pack == next_pack && !chunk_overflow) begin
            sx = b64_value(ch);
            if (sx >= 0) begin
                cap = (int'(decode_limit_q) < BUF_BYTES) ? int'(decode_limit_q) : BUF_BYTES;
                bit_window = {bit_window[5:0], 6'(sx)};
                bit_pos += 6;
                if (bit_pos >= 0) begin
                    if (chunk_bytes >= cap) begin
                        chunk_overflow = 1'b1;
                    end else begin
                        shifted = bit_window >> bit_pos;
                        val = shifted[7:0];
                        got = 1'b1;
                        chunk_bytes++;
                        chunk_crc = crc16_step(chunk_crc, val);
                    end
                    bit_pos -= 8;
                end
            end
        end
        if (!fin || pack == 0) begin
            // chunk number zero closes the chunk silently
            if (fin) clear_chunk_state();
            if (got) push_due(KIND_DATA, val, ST_OK, '0, 1'b1);
            return;
        end
        if (got) push_due(KIND_DATA, val, ST_OK, '0, 1'b0);
        if (pack != next_pack) begin
            push_due(KIND_REPORT, '0, ST_SEQUENCE, next_pack, 1'b1);
        end else if (chunk_bytes == 0 || chunk_overflow || chunk_bytes > int'(max_chunk_q)) begin
            push_due(KIND_REPORT, '0, ST_DECODE, pack, 1'b1);
        end else if (ecrc != 0 && ecrc != chunk_crc) begin
            push_due(KIND_REPORT, '0, ST_CRC, pack, 1'b1);
        end else begin
            sum = {1'b0, written_total} + 25'(chunk_bytes);
            written_total = (sum > {1'b0, WRITTEN_MAX}) ? WRITTEN_MAX : sum[23:0];
            next_pack = next_pack + 1'b1;
            push_due(KIND_REPORT, '0, ST_OK, pack, 1'b1);
        end
        clear_chunk_state();
    endtask

    task automatic send_item(input logic req, input logic [PACK_W-1:0] pack,
                             input logic [CRC_W-1:0] ecrc, input logic [7:0] ch,
                             input logic fin);
        if (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < tx_idle_pct);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {ch, ecrc, pack};
        s_tuser  <= req;
        s_tlast  <= fin;
        do @(posedge aclk); while (!s_tready);
        advance_decoder(req, pack, ecrc, ch, fin);
        items_sent++;
    endtask

    task automatic send_text(input logic [PACK_W-1:0] pack, input logic [CRC_W-1:0] ecrc,
                             input string txt);
        for (int i = 0; i < txt.len(); i++)
            send_item(REQ_CHAR, pack, ecrc, txt[i], i == txt.len() - 1);
    endtask

    // wait for every queued result, then for the pipeline to settle
    task automatic drain_results();
        int waited;
        waited = 0;
        s_tvalid <= 1'b0;
        while (due_results.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge aclk);
            waited++;
        end
        if (due_results.size() != 0) begin
            $display("%0d results never arrived", due_results.size());
            mismatches += due_results.size();
            due_results.delete();
        end
        repeat (8) @(posedge aclk);
    endtask

    task automatic set_limits(input logic [CNT_W-1:0] limit, input logic [CNT_W-1:0] maxc);
        cfg_valid <= 1'b1;
        cfg_index <= CFG_DECODE_LIMIT;
        cfg_data  <= limit;
        do @(posedge aclk); while (!cfg_ready);
        decode_limit_q = limit;
        cfg_index <= CFG_MAX_CHUNK;
        cfg_data  <= maxc;
        do @(posedge aclk); while (!cfg_ready);
        max_chunk_q = maxc;
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [7:0] noise_char();
        case ($urandom_range(5))
            0: return "=";
            1: return 8'h0A;
            2: return 8'h0D;
            3: return 8'h20;
            4: return 8'h00;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    // one chunk: random payload, base64 text with stray characters mixed in
    task automatic send_random_chunk();
        int               len;
        int               r;
        logic [PACK_W-1:0] pack;
        logic [CRC_W-1:0]  good;
        logic [CRC_W-1:0]  ecrc;
        logic [23:0]       grp;
        int                n;
        logic              fin;
        len = ($urandom_range(99) < 85) ? $urandom_range(0, 24) : $urandom_range(25, 48);
        r = $urandom_range(99);
        pack = (r < 75) ? next_pack : (r < 85) ? '0 : 16'($urandom);
        payload.delete();
        chunk_text.delete();
        good = CRC_INIT;
        for (int i = 0; i < len; i++) begin
            payload.push_back(8'($urandom));
            good = crc16_step(good, payload[i]);
        end
        for (int i = 0; i < len; i += 3) begin
            n = (len - i >= 3) ? 3 : len - i;
            grp = {payload[i], (n > 1) ? payload[i+1] : 8'h00, (n > 2) ? payload[i+2] : 8'h00};
            chunk_text.push_back(B64_CHARS[grp[23:18]]);
            chunk_text.push_back(B64_CHARS[grp[17:12]]);
            chunk_text.push_back((n > 1) ? B64_CHARS[grp[11:6]] : "=");
            chunk_text.push_back((n > 2) ? B64_CHARS[grp[5:0]] : "=");
        end
        if (chunk_text.size() == 0) chunk_text.push_back(noise_char());
        r = $urandom_range(99);
        ecrc = (r < 60) ? good : (r < 80) ? '0 : good ^ 16'($urandom_range(1, 65535));
        for (int i = 0; i < chunk_text.size(); i++) begin
            fin = (i == chunk_text.size() - 1);
            if ($urandom_range(99) < 8)
                send_item(REQ_CHAR, pack, 16'($urandom), noise_char(), 1'b0);
            // now and then a character from some other chunk slips in
            if ($urandom_range(99) < 5)
                send_item(REQ_CHAR, pack ^ 16'($urandom_range(1, 65535)), 16'($urandom),
                          chunk_text[i], 1'b0);
            else
                send_item(REQ_CHAR, pack, fin ? ecrc : 16'($urandom), chunk_text[i], fin);
        end
    endtask

    task automatic run_stream(input int tx_pct, input int rx_pct,
                              input logic [CNT_W-1:0] limit, input logic [CNT_W-1:0] maxc,
                              input int count);
        int stop_at;
        int r;
        drain_results();
        set_limits(limit, maxc);
        tx_idle_pct  = tx_pct;
        rx_stall_pct = rx_pct;
        stop_at = items_sent + count;
        send_item(REQ_START, 16'($urandom), 16'($urandom), 8'($urandom), 1'($urandom));
        while (items_sent < stop_at) begin
            r = $urandom_range(99);
            if (r < 6)
                send_item(REQ_START, 16'($urandom), 16'($urandom), 8'($urandom),
                          1'($urandom));
            else if (r < 16)
                send_item(1'($urandom), 16'($urandom), 16'($urandom), 8'($urandom),
                          1'($urandom));
            else
                send_random_chunk();
        end
        drain_results();
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
    endtask

    task automatic test_directed_cases();
        send_item(REQ_START, 16'hFFFF, 16'hFFFF, 8'hFF, 1'b0);
        send_text(16'd1, 16'd0, "+/Az09");          // byte on the last character
        send_text(16'd2, 16'd0, "=");               // empty chunk
        send_text(16'd5, 16'd0, "QQ");              // out of sequence
        send_text(16'd0, 16'd0, "QQ");              // chunk number zero
        send_item(REQ_CHAR, 16'd2, 16'd0, "/", 1'b0);
        send_item(REQ_CHAR, 16'd2, 16'd0, 8'hFF, 1'b0);
        send_item(REQ_CHAR, 16'd2, 16'd0, 8'h00, 1'b0);
        send_item(REQ_CHAR, 16'd2, 16'hFFFF, "w", 1'b1);
        drain_results();
        set_limits(13'd1, 13'd4096);
        send_text(16'd2, 16'd0, "AAAA");            // buffer overflow
        drain_results();
        set_limits(13'd4096, 13'd1);
        send_text(16'd2, 16'd0, "AAA");             // over the chunk limit
        send_item(REQ_CHAR, 16'd2, 16'd0, "A", 1'b0);
        send_item(REQ_START, 16'h0000, 16'h0000, 8'h00, 1'b1);  // start mid-chunk
        drain_results();
    endtask

    task automatic test_stream_no_idle();
        run_stream(0, 0, 13'd4096, 13'd4096, 600);
    endtask

    task automatic test_stream_sender_gaps();
        run_stream(64, 0, 13'd20, 13'd12, 500);
    endtask

    task automatic test_stream_receiver_stalls();
        run_stream(0, 64, 13'd1, 13'd1, 300);
    endtask

    task automatic test_stream_both_idle();
        run_stream(16, 16, 13'($urandom_range(2, 40)), 13'($urandom_range(2, 40)), 500);
    endtask

    // result checker and receiver back-pressure
    always @(posedge aclk) begin
        result_t want;
        result_t seen;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                seen.kind          = m_tuser[0];
                seen.data_byte     = m_tdata[7:0];
                seen.status        = status_t'(m_tdata[9:8]);
                seen.reported_pack = m_tdata[25:10];
                seen.total_written = m_tdata[49:26];
                seen.last          = m_tlast;
                results_seen++;
                if (due_results.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result at %0t: kind %0d byte %02h status %0d",
                                 $time, seen.kind, seen.data_byte, seen.status);
                end else begin
                    want = due_results.pop_front();
                    if (want.kind == KIND_REPORT) reports_by_status[want.status]++;
                    if (seen.kind !== want.kind || seen.data_byte !== want.data_byte ||
                        seen.status !== want.status ||
                        seen.reported_pack !== want.reported_pack ||
                        seen.total_written !== want.total_written ||
                        seen.last !== want.last) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display("mismatch at %0t", $time);
                            $display("  expected kind %0d byte %02h status %0d pack %0d written %0d last %0d",
                                     want.kind, want.data_byte, want.status,
                                     want.reported_pack, want.total_written, want.last);
                            $display("  actual   kind %0d byte %02h status %0d pack %0d written %0d last %0d",
                                     seen.kind, seen.data_byte, seen.status,
                                     seen.reported_pack, seen.total_written, seen.last);
                        end
                    end
                end
            end
            m_tready <= (rx_stall_pct == 0) || ($urandom_range(99) >= rx_stall_pct);
        end
    end

    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed_cases();
        test_stream_no_idle();
        test_stream_sender_gaps();
        test_stream_receiver_stalls();
        test_stream_both_idle();
        drain_results();
        $display("sent %0d items over four idle patterns and seven limit settings",
                 items_sent);
        $display("checked %0d results; reports ok %0d, sequence %0d, decode %0d, crc %0d",
                 results_seen, reports_by_status[0], reports_by_status[1],
                 reports_by_status[2], reports_by_status[3]);
        if (mismatches == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    initial begin
        #5000000;
        $display("run timed out");
        $display("FAILURE");
        $finish;
    end

endmodule
